// ===== design/gbld_pkg.sv =====
// ---------------------------------------------------------------------------
// gbld_pkg: shared types and constants of the GNSS binary log deframer
// Token format between the front and the back, result codes, header byte
// positions and the bytewise reflected CRC-32 step.
// ---------------------------------------------------------------------------
`default_nettype none

package gbld_pkg;

   localparam int HEADER_BYTES = 28;

   localparam logic [7:0] SYNC_0 = 8'hAA;
   localparam logic [7:0] SYNC_1 = 8'h44;
   localparam logic [7:0] SYNC_2 = 8'h12;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // header byte positions, counted from the first sync byte
   localparam int POS_HDR_LEN = 3;
   localparam int POS_ID      = 4;
   localparam int POS_LEN     = 8;
   localparam int POS_WEEK    = 14;
   localparam int POS_MS      = 16;
   localparam int POS_STATUS  = 20;

   localparam int POS_W = $clog2(HEADER_BYTES);

   // configuration register indexes
   localparam logic [7:0] REG_EXP_HDR_LEN = 8'd0;
   localparam logic [7:0] REG_MAX_PAYLOAD = 8'd1;

   localparam logic [7:0]  EXP_HDR_LEN_RESET = 8'd28;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ABORT    = 2'd2;

   // abort codes
   localparam logic [1:0] ABORT_NONE    = 2'd0;
   localparam logic [1:0] ABORT_BAD_HDR = 2'd1;
   localparam logic [1:0] ABORT_ZERO    = 2'd2;
   localparam logic [1:0] ABORT_LONG    = 2'd3;

   // token operations
   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_CRC     = 3'd1;
   localparam logic [2:0] OP_HDR     = 3'd2;
   localparam logic [2:0] OP_ABORT   = 3'd3;
   localparam logic [2:0] OP_PAYLOAD = 3'd4;
   localparam logic [2:0] OP_TRAILER = 3'd5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  data;
      logic [15:0] arg;    // header position, payload index or trailer byte index
      logic [1:0]  code;
   } token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] v;
      v = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return {8'd0, crc[31:8]} ^ v;
   endfunction

endpackage

`default_nettype wire

// ===== design/gbld_front.sv =====
// ---------------------------------------------------------------------------
// gbld_front: frame tracker
// Accepts received bytes, follows sync, header, payload and trailer, makes
// the abort decisions and queues one token per byte that is not dropped.
// Holds the configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module gbld_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_rx_byte,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [7:0]                 csr_index,
   input  wire logic [15:0]                csr_data,
   input  wire gbld_pkg::queue_status_type q_status,
   output logic                            push,
   output gbld_pkg::token_type             push_token
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_TRAILER = 2'd3;

   localparam int PW = gbld_pkg::POS_W;

   logic [1:0]    phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   pcnt_ff, pcnt_in;
   logic [1:0]    tcnt_ff, tcnt_in;
   logic [7:0]    len_lo_ff, len_lo_in;
   logic [15:0]   len_ff, len_in;
   logic [7:0]    exp_len_ff;
   logic [15:0]   max_len_ff;

   logic          take;
   logic [7:0]    want;
   logic [15:0]   len_word;
   logic [15:0]   pcnt_next;

   assign req_ready = !q_status.full;
   assign csr_ready = 1'b1;
   assign take      = req_valid && req_ready;
   assign len_word  = {req_rx_byte, len_lo_ff};
   assign pcnt_next = pcnt_ff + 16'd1;

   always_comb begin
      case (pos_ff)
         PW'(0):  want = gbld_pkg::SYNC_0;
         PW'(1):  want = gbld_pkg::SYNC_1;
         default: want = gbld_pkg::SYNC_2;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      pcnt_in    = pcnt_ff;
      tcnt_in    = tcnt_ff;
      len_lo_in  = len_lo_ff;
      len_in     = len_ff;
      push       = 1'b0;
      push_token = '0;
      push_token.data = req_rx_byte;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (pos_ff > PW'(2) || req_rx_byte != want) begin
                  pos_in = '0;    // wrong byte is dropped
               end else begin
                  push          = 1'b1;
                  push_token.op = (pos_ff == '0) ? gbld_pkg::OP_START : gbld_pkg::OP_CRC;
                  pos_in        = pos_ff + PW'(1);
                  if (pos_ff == '0) begin
                     pcnt_in = '0;
                     tcnt_in = '0;
                  end
                  if (pos_ff == PW'(2)) begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_HEADER: begin
               push           = 1'b1;
               push_token.op  = gbld_pkg::OP_HDR;
               push_token.arg = 16'(pos_ff);
               if (pos_ff == PW'(gbld_pkg::POS_LEN)) begin
                  len_lo_in = req_rx_byte;
               end
               if (pos_ff == PW'(gbld_pkg::POS_LEN + 1)) begin
                  len_in = len_word;
               end
               if (pos_ff == PW'(gbld_pkg::POS_HDR_LEN) && req_rx_byte != exp_len_ff) begin
                  push_token.op   = gbld_pkg::OP_ABORT;
                  push_token.code = gbld_pkg::ABORT_BAD_HDR;
               end else if (pos_ff == PW'(gbld_pkg::POS_LEN + 1) && len_word == 16'd0) begin
                  push_token.op   = gbld_pkg::OP_ABORT;
                  push_token.code = gbld_pkg::ABORT_ZERO;
               end else if (pos_ff == PW'(gbld_pkg::POS_LEN + 1) && len_word > max_len_ff) begin
                  push_token.op   = gbld_pkg::OP_ABORT;
                  push_token.code = gbld_pkg::ABORT_LONG;
               end
               if (push_token.op == gbld_pkg::OP_ABORT) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
                  pcnt_in  = '0;
                  tcnt_in  = '0;
               end else if (pos_ff == PW'(gbld_pkg::HEADER_BYTES - 1)) begin
                  phase_in = PH_PAYLOAD;
                  pos_in   = '0;
                  pcnt_in  = '0;
               end else begin
                  pos_in = pos_ff + PW'(1);
               end
            end
            PH_PAYLOAD: begin
               push           = 1'b1;
               push_token.op  = gbld_pkg::OP_PAYLOAD;
               push_token.arg = pcnt_ff;
               pcnt_in        = pcnt_next;
               if (pcnt_next == len_ff || pcnt_next == 16'd0) begin
                  phase_in = PH_TRAILER;
                  tcnt_in  = '0;
               end
            end
            default: begin
               push           = 1'b1;
               push_token.op  = gbld_pkg::OP_TRAILER;
               push_token.arg = 16'(tcnt_ff);
               if (tcnt_ff == 2'd3) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
                  pcnt_in  = '0;
                  tcnt_in  = '0;
               end else begin
                  tcnt_in = tcnt_ff + 2'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         pos_ff     <= '0;
         pcnt_ff    <= '0;
         tcnt_ff    <= '0;
         len_lo_ff  <= '0;
         len_ff     <= '0;
         exp_len_ff <= gbld_pkg::EXP_HDR_LEN_RESET;
         max_len_ff <= gbld_pkg::MAX_PAYLOAD_RESET;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         pcnt_ff   <= pcnt_in;
         tcnt_ff   <= tcnt_in;
         len_lo_ff <= len_lo_in;
         len_ff    <= len_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gbld_pkg::REG_EXP_HDR_LEN: exp_len_ff <= csr_data[7:0];
               gbld_pkg::REG_MAX_PAYLOAD: max_len_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/gbld_fifo.sv =====
// ---------------------------------------------------------------------------
// gbld_fifo: token queue
// Short first-in first-out queue of tokens between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module gbld_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire gbld_pkg::token_type  push_token,
   input  wire logic                 pop,
   output gbld_pkg::token_type       pop_token,
   output gbld_pkg::queue_status_type status
);

   localparam int D  = gbld_pkg::QUEUE_DEPTH;
   localparam int PW = gbld_pkg::QUEUE_PTR_W;
   localparam int CW = gbld_pkg::QUEUE_CNT_W;

   gbld_pkg::token_type entry_ff [D];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign status.full  = (cnt_ff == CW'(D));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_token    = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(D - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(D - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

// ===== design/gbld_back.sv =====
// ---------------------------------------------------------------------------
// gbld_back: frame executor
// Runs the CRC, captures header fields and the trailer, and forms result
// items in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gbld_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gbld_pkg::token_type        tok,
   input  wire gbld_pkg::queue_status_type q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_payload_byte,
   output logic [15:0]                     rsp_payload_index,
   output logic [15:0]                     rsp_message_id,
   output logic [15:0]                     rsp_message_length,
   output logic [15:0]                     rsp_week_number,
   output logic [31:0]                     rsp_week_milliseconds,
   output logic [31:0]                     rsp_receiver_status,
   output logic                            rsp_crc_ok,
   output logic [1:0]                      rsp_abort_code
);

   localparam int PW = gbld_pkg::POS_W;

   logic [31:0] crc_ff, crc_in;
   logic [23:0] rcv_ff, rcv_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] week_ff, week_in;
   logic [31:0] ms_ff, ms_in;
   logic [31:0] status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        emit;
   logic        last_trailer;
   logic [PW-1:0] pos;
   logic [7:0]  b;

   assign b            = tok.data;
   assign pos          = tok.arg[PW-1:0];
   assign last_trailer = (tok.op == gbld_pkg::OP_TRAILER) && (tok.arg[1:0] == 2'd3);
   assign emit         = (tok.op == gbld_pkg::OP_PAYLOAD) || (tok.op == gbld_pkg::OP_ABORT)
                         || last_trailer;
   assign pop          = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      crc_in    = crc_ff;
      rcv_in    = rcv_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      week_in   = week_ff;
      ms_in     = ms_ff;
      status_in = status_ff;
      if (tok.op == gbld_pkg::OP_START) begin
         crc_in    = gbld_pkg::crc_byte(32'd0, b);
         id_in     = '0;
         len_in    = '0;
         week_in   = '0;
         ms_in     = '0;
         status_in = '0;
      end else if (tok.op == gbld_pkg::OP_TRAILER) begin
         case (tok.arg[1:0])
            2'd0:    rcv_in[7:0]   = b;
            2'd1:    rcv_in[15:8]  = b;
            2'd2:    rcv_in[23:16] = b;
            default: ;
         endcase
      end else begin
         crc_in = gbld_pkg::crc_byte(crc_ff, b);
         if (tok.op == gbld_pkg::OP_HDR || tok.op == gbld_pkg::OP_ABORT) begin
            case (pos)
               PW'(gbld_pkg::POS_ID):         id_in[7:0]       = b;
               PW'(gbld_pkg::POS_ID + 1):     id_in[15:8]      = b;
               PW'(gbld_pkg::POS_LEN):        len_in[7:0]      = b;
               PW'(gbld_pkg::POS_LEN + 1):    len_in[15:8]     = b;
               PW'(gbld_pkg::POS_WEEK):       week_in[7:0]     = b;
               PW'(gbld_pkg::POS_WEEK + 1):   week_in[15:8]    = b;
               PW'(gbld_pkg::POS_MS):         ms_in[7:0]       = b;
               PW'(gbld_pkg::POS_MS + 1):     ms_in[15:8]      = b;
               PW'(gbld_pkg::POS_MS + 2):     ms_in[23:16]     = b;
               PW'(gbld_pkg::POS_MS + 3):     ms_in[31:24]     = b;
               PW'(gbld_pkg::POS_STATUS):     status_in[7:0]   = b;
               PW'(gbld_pkg::POS_STATUS + 1): status_in[15:8]  = b;
               PW'(gbld_pkg::POS_STATUS + 2): status_in[23:16] = b;
               PW'(gbld_pkg::POS_STATUS + 3): status_in[31:24] = b;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         crc_ff    <= crc_in;
         rcv_ff    <= rcv_in;
         id_ff     <= id_in;
         len_ff    <= len_in;
         week_ff   <= week_in;
         ms_ff     <= ms_in;
         status_ff <= status_in;
      end
      if (pop && emit) begin
         rsp_message_id        <= id_in;
         rsp_message_length    <= len_in;
         rsp_week_number       <= week_in;
         rsp_week_milliseconds <= ms_in;
         rsp_receiver_status   <= status_in;
         rsp_payload_byte      <= '0;
         rsp_payload_index     <= '0;
         rsp_crc_ok            <= 1'b0;
         rsp_abort_code        <= gbld_pkg::ABORT_NONE;
         if (tok.op == gbld_pkg::OP_PAYLOAD) begin
            rsp_kind          <= gbld_pkg::KIND_PAYLOAD;
            rsp_payload_byte  <= b;
            rsp_payload_index <= tok.arg;
         end else if (tok.op == gbld_pkg::OP_ABORT) begin
            rsp_kind       <= gbld_pkg::KIND_ABORT;
            rsp_abort_code <= tok.code;
         end else begin
            rsp_kind   <= gbld_pkg::KIND_COMPLETE;
            rsp_crc_ok <= ({b, rcv_ff} == crc_ff);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/gnss_binary_log_deframer.sv =====
// ---------------------------------------------------------------------------
// gnss_binary_log_deframer: binary log deframer with reflected CRC-32
// Hunts for sync, checks and captures the header, passes payload bytes and
// checks the CRC trailer, reporting a summary or an abort per frame.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_rx_byte
//  rsp      out        rsp_valid/rsp_ready  rsp_kind .. rsp_abort_code
//  csr      in         csr_valid/csr_ready  csr_index, csr_data
//
//  One byte per cycle sustained while rsp_ready stays high; each accepted
//  byte's token is written to the queue, and the output register is loaded
//  from the queue when it is free. The two-entry token queue lets the front
//  keep taking bytes while a result waits on rsp_ready, until it is full.
//  Synchronous reset returns to the sync hunt and restores register
//  defaults; csr_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module gnss_binary_log_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_payload_index,
   output logic [15:0]      rsp_message_id,
   output logic [15:0]      rsp_message_length,
   output logic [15:0]      rsp_week_number,
   output logic [31:0]      rsp_week_milliseconds,
   output logic [31:0]      rsp_receiver_status,
   output logic             rsp_crc_ok,
   output logic [1:0]       rsp_abort_code,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   gbld_pkg::queue_status_type q_status;
   gbld_pkg::token_type        push_token;
   gbld_pkg::token_type        pop_token;
   logic                       push;
   logic                       pop;

   gbld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .push        (push),
      .push_token  (push_token)
   );

   gbld_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .pop_token  (pop_token),
      .status     (q_status)
   );

   gbld_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .tok                   (pop_token),
      .q_status              (q_status),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_payload_byte      (rsp_payload_byte),
      .rsp_payload_index     (rsp_payload_index),
      .rsp_message_id        (rsp_message_id),
      .rsp_message_length    (rsp_message_length),
      .rsp_week_number       (rsp_week_number),
      .rsp_week_milliseconds (rsp_week_milliseconds),
      .rsp_receiver_status   (rsp_receiver_status),
      .rsp_crc_ok            (rsp_crc_ok),
      .rsp_abort_code        (rsp_abort_code)
   );

endmodule

`default_nettype wire

// ===== design/gbld_checker.sv =====
// ---------------------------------------------------------------------------
// gbld_checker: port-level checks for the deframer
// Watches the top level ports and flags inconsistent result items.
// ---------------------------------------------------------------------------
`default_nettype none

module gbld_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_crc_ok,
   input wire logic [1:0] rsp_abort_code
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_payload_byte))
      else $error("result item changed while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == gbld_pkg::KIND_PAYLOAD
         || rsp_kind == gbld_pkg::KIND_COMPLETE || rsp_kind == gbld_pkg::KIND_ABORT))
      else $error("undefined result kind");

   // only an abort carries an abort code, and it always carries one
   a_abort_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == gbld_pkg::KIND_ABORT)
         == (rsp_abort_code != gbld_pkg::ABORT_NONE)))
      else $error("abort code does not match item kind");

   a_crc_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != gbld_pkg::KIND_COMPLETE |-> !rsp_crc_ok)
      else $error("crc flag set outside a frame summary");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gnss_binary_log_deframer gbld_checker u_gbld_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_crc_ok       (rsp_crc_ok),
   .rsp_abort_code   (rsp_abort_code)
);

`default_nettype wire
